@@ design/text_console_scroll_dirty_map_assert.svh @@
// Assertion macros for the text console scroll and dirty map block.
// Used by the sequencer module; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_SCROLL_DIRTY_MAP_ASSERT_SVH
`define TEXT_CONSOLE_SCROLL_DIRTY_MAP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TCSDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define TCSDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tcsdm_pkg.sv @@
// Shared types and constants of the text console scroll and dirty map block.
// Used by the sequencer, output register and top module; depends on nothing.
package tcsdm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CNT_W      = 13;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd4;

  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic [6:0] cols;
    logic [5:0] rows;
    logic [4:0] line_height;
    logic [2:0] x_off;
    logic [3:0] y_off;
  } cfg_t;

  typedef struct packed {
    logic       dirty;
    logic [7:0] ch;
  } cell_t;

  localparam int unsigned CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] glyph;
    logic       last;
  } draw_t;

endpackage

@@ design/tcsdm_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; holds the character cells and their dirty marks.
module tcsdm_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ design/tcsdm_outbuf.sv @@
// One-entry output register for draw commands.
// Depends on tcsdm_pkg for the draw command type.
module tcsdm_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  tcsdm_pkg::draw_t  push_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcsdm_pkg::draw_t  out_o
);

  logic             valid_q;
  tcsdm_pkg::draw_t data_q;

  assign push_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_valid_i && push_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      data_q <= push_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

@@ design/tcsdm_seq.sv @@
// Sequencer and shared cell compare/write unit of the console block.
// Depends on tcsdm_pkg and the assertion macro header; drives tcsdm_ram.
`include "text_console_scroll_dirty_map_assert.svh"

module tcsdm_seq #(
  parameter int unsigned DEPTH      = 2048,
  parameter int unsigned CELL_WIDTH = 6,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcsdm_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [7:0]                    char_code_i,
  input  logic [4:0]                    row_index_i,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [tcsdm_pkg::CELL_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_a_o,
  input  logic [tcsdm_pkg::CELL_W-1:0]  ram_rdata_a_i,
  output logic [AW-1:0]                 ram_raddr_b_o,
  input  logic [tcsdm_pkg::CELL_W-1:0]  ram_rdata_b_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output tcsdm_pkg::draw_t              push_o
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_WC_RD    = 10'b00_0000_0100,
    S_WC_WR    = 10'b00_0000_1000,
    S_SC_SETUP = 10'b00_0001_0000,
    S_SC_RD    = 10'b00_0010_0000,
    S_SC_WR    = 10'b00_0100_0000,
    S_UP_RD    = 10'b00_1000_0000,
    S_UP_CHK   = 10'b01_0000_0000,
    S_UP_FLUSH = 10'b10_0000_0000
  } state_e;

  localparam int unsigned CW = tcsdm_pkg::CNT_W;

  state_e                  state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [6:0]              cursor_q, cursor_d;
  logic [7:0]              ch_q, ch_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           base_q, base_d;
  logic [6:0]              col_q, col_d;
  logic [9:0]              x_q, x_d;
  logic [9:0]              py_q, py_d;
  tcsdm_pkg::draw_t        pend_q, pend_d;
  logic                    pend_v_q, pend_v_d;

  tcsdm_pkg::cell_t        rdata_a;
  tcsdm_pkg::cell_t        rdata_b;
  tcsdm_pkg::cell_t        wdata;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr_a;
  logic [AW-1:0]           raddr_b;
  logic                    push_valid;
  tcsdm_pkg::draw_t        push;
  logic [6:0]              cursor_nx;
  logic                    cur_in_rng;
  logic [7:0]              src_ch;
  logic                    advance;
  logic [5:0]              rows_above;

  assign rdata_a    = tcsdm_pkg::cell_t'(ram_rdata_a_i);
  assign rdata_b    = tcsdm_pkg::cell_t'(ram_rdata_b_i);
  assign cursor_nx  = cursor_q + 7'd1;
  assign cur_in_rng = 32'(cursor_q) < DEPTH;
  assign src_ch     = (idx_q >= CW'(cfg_i.cols)) ? rdata_b.ch : tcsdm_pkg::SPACE_CODE;
  assign rows_above = cfg_i.rows - {1'b0, row_index_i} - 6'd1;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cursor_d   = cursor_q;
    ch_d       = ch_q;
    idx_d      = idx_q;
    base_d     = base_q;
    col_d      = col_q;
    x_d        = x_q;
    py_d       = py_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '{dirty: 1'b0, ch: tcsdm_pkg::SPACE_CODE};
    raddr_a    = '0;
    raddr_b    = '0;
    push_valid = 1'b0;
    push       = pend_q;
    advance    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d = char_code_i;
          if (cmd_i == tcsdm_pkg::CMD_WRITE) begin
            if (char_code_i == tcsdm_pkg::NEWLINE_CODE) begin
              state_d = S_SC_SETUP;
            end else if (char_code_i >= tcsdm_pkg::SPACE_CODE) begin
              state_d = S_WC_RD;
            end
          end else if ({1'b0, row_index_i} < cfg_i.rows) begin
            base_d   = CW'(row_index_i) * CW'(cfg_i.cols);
            py_d     = 10'(12'(cfg_i.y_off) + 12'(cfg_i.line_height) * 12'(rows_above));
            col_d    = '0;
            x_d      = 10'(cfg_i.x_off);
            pend_v_d = 1'b0;
            state_d  = S_UP_RD;
          end
        end
      end
      S_WC_RD: begin
        raddr_a = AW'(cursor_q);
        state_d = S_WC_WR;
      end
      S_WC_WR: begin
        raddr_a = AW'(cursor_q);
        if (cur_in_rng && rdata_a.ch != ch_q) begin
          we    = 1'b1;
          waddr = AW'(cursor_q);
          wdata = '{dirty: 1'b1, ch: ch_q};
        end
        cursor_d = cursor_nx;
        state_d  = (cursor_nx >= cfg_i.cols) ? S_SC_SETUP : S_IDLE;
      end
      S_SC_SETUP: begin
        idx_d   = CW'(cfg_i.rows) * CW'(cfg_i.cols) - CW'(1);
        state_d = S_SC_RD;
      end
      S_SC_RD: begin
        raddr_a = AW'(idx_q);
        raddr_b = AW'(idx_q - CW'(cfg_i.cols));
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        if (rdata_a.ch != src_ch) begin
          we    = 1'b1;
          waddr = AW'(idx_q);
          wdata = '{dirty: 1'b1, ch: src_ch};
        end
        if (idx_q == '0) begin
          cursor_d = '0;
          state_d  = S_IDLE;
        end else begin
          idx_d   = idx_q - CW'(1);
          state_d = S_SC_RD;
        end
      end
      S_UP_RD: begin
        raddr_a = AW'(base_q + CW'(col_q));
        state_d = S_UP_CHK;
      end
      S_UP_CHK: begin
        raddr_a = AW'(base_q + CW'(col_q));
        advance = 1'b1;
        if (rdata_a.dirty) begin
          if (pend_v_q && !push_ready_i) begin
            advance    = 1'b0;
            push_valid = 1'b1;
            push.last  = 1'b0;
          end else begin
            push_valid = pend_v_q;
            push.last  = 1'b0;
            we         = 1'b1;
            waddr      = AW'(base_q + CW'(col_q));
            wdata      = '{dirty: 1'b0, ch: rdata_a.ch};
            pend_d     = '{pixel_x: x_q, pixel_y: py_q, glyph: rdata_a.ch, last: 1'b0};
            pend_v_d   = 1'b1;
          end
        end
        if (advance) begin
          if (col_q == cfg_i.cols - 7'd1) begin
            state_d = S_UP_FLUSH;
          end else begin
            col_d   = col_q + 7'd1;
            x_d     = x_q + 10'(CELL_WIDTH);
            state_d = S_UP_RD;
          end
        end
      end
      S_UP_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else begin
          push_valid = 1'b1;
          push.last  = 1'b1;
          if (push_ready_i) begin
            pend_v_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      cursor_q <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    idx_q  <= idx_d;
    base_q <= base_d;
    col_q  <= col_d;
    x_q    <= x_d;
    py_q   <= py_d;
    pend_q <= pend_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign ram_we_o      = we;
  assign ram_waddr_o   = waddr;
  assign ram_wdata_o   = wdata;
  assign ram_raddr_a_o = raddr_a;
  assign ram_raddr_b_o = raddr_b;
  assign push_valid_o  = push_valid;
  assign push_o        = push;

  `TCSDM_ASSERT(a_last_only_in_flush, (push_valid && push.last) |-> (state_q == S_UP_FLUSH), "Final draw word issued outside the flush step.")
  `TCSDM_ASSERT(a_update_only_clears, (we && state_q == S_UP_CHK) |-> !wdata.dirty, "Row update set a dirty mark.")
  `TCSDM_ASSERT(a_push_has_pending, push_valid |-> pend_v_q, "Draw word issued with no pending command.")
  `TCSDM_ASSERT_NEXT(a_scroll_homes_cursor, (state_q == S_SC_WR && idx_q == '0), (cursor_q == 7'd0), "Cursor not home after scroll.")
  `TCSDM_ASSERT_NEXT(a_stall_holds_cell, (state_q == S_UP_CHK && rdata_a.dirty && pend_v_q && !push_ready_i), (state_q == S_UP_CHK && $stable(col_q)), "Row update moved on while stalled.")

endmodule

@@ design/text_console_scroll_dirty_map.sv @@
// Text console buffer with per-cell dirty marks and row-wise redraw.
// Input words on in_valid_i/in_ready_o: cmd_i 0 writes char_code_i to the
// bottom row, cmd_i 1 redraws row row_index_i. Draw words leave on
// out_valid_o/out_ready_i with pixel_x_o, pixel_y_o, glyph_o and last_o.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the
// user must write them only while the block is idle; it is not enforced.
// After reset the block sweeps the cell memory, one cell a cycle, writing
// spaces and clearing the dirty marks in all MAX_COLS*MAX_ROWS cells, and
// no input word is taken meanwhile.
// A control code other than newline is ignored.
// A printable character is written at the cursor if it differs. A newline
// scrolls the memory, comparing each of the rows*cols cells and writing it
// if changed, and homes the cursor; a row-filling character also scrolls.
// A row update can be held up by a stalled receiver, and its draw words
// leave in column order with last_o on the final one. One output register
// sits on the draw side; a stalled receiver holds the sequencer on the
// next dirty cell.
// Only one input word is worked on at a time.
module text_console_scroll_dirty_map #(
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned CELL_WIDTH = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tcsdm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcsdm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [7:0]                        char_code_i,
  input  logic [4:0]                        row_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [9:0]                        pixel_x_o,
  output logic [9:0]                        pixel_y_o,
  output logic [7:0]                        glyph_o,
  output logic                              last_o
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [6:0]              cols_used_q;
  logic [5:0]              rows_used_q;
  logic [4:0]              line_height_q;
  logic [2:0]              x_offset_q;
  logic [3:0]              y_offset_q;
  tcsdm_pkg::cfg_t         cfg;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [tcsdm_pkg::CELL_W-1:0]    ram_wdata;
  logic [AW-1:0]                   ram_raddr_a;
  logic [tcsdm_pkg::CELL_W-1:0]    ram_rdata_a;
  logic [AW-1:0]                   ram_raddr_b;
  logic [tcsdm_pkg::CELL_W-1:0]    ram_rdata_b;
  logic                            push_valid;
  logic                            push_ready;
  tcsdm_pkg::draw_t                push;
  tcsdm_pkg::draw_t                out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_used_q   <= 7'd32;
      rows_used_q   <= 6'd32;
      line_height_q <= 5'd9;
      x_offset_q    <= 3'd0;
      y_offset_q    <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcsdm_pkg::REG_COLS_USED:   cols_used_q   <= cfg_wdata_i[6:0];
        tcsdm_pkg::REG_ROWS_USED:   rows_used_q   <= cfg_wdata_i[5:0];
        tcsdm_pkg::REG_LINE_HEIGHT: line_height_q <= cfg_wdata_i[4:0];
        tcsdm_pkg::REG_X_OFFSET:    x_offset_q    <= cfg_wdata_i[2:0];
        tcsdm_pkg::REG_Y_OFFSET:    y_offset_q    <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.cols = (cols_used_q == 7'd0) ? 7'd1 :
               (cols_used_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_used_q;
    cfg.rows = (rows_used_q == 6'd0) ? 6'd1 :
               ({1'b0, rows_used_q} > 7'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_used_q;
    cfg.line_height = line_height_q;
    cfg.x_off       = x_offset_q;
    cfg.y_off       = y_offset_q;
  end

  tcsdm_ram #(
    .WIDTH (tcsdm_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  tcsdm_seq #(
    .DEPTH      (DEPTH),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .char_code_i   (char_code_i),
    .row_index_i   (row_index_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_b_i (ram_rdata_b),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_o        (push)
  );

  tcsdm_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out)
  );

  assign pixel_x_o = out.pixel_x;
  assign pixel_y_o = out.pixel_y;
  assign glyph_o   = out.glyph;
  assign last_o    = out.last;

endmodule
